[design/bpa_pkg.sv]
// Package: shared types and constants for the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  localparam int FRAME_W = 52;
  localparam int CNT_W   = 13;

  typedef enum logic [1:0] {
    ACT_ALLOC_ONE = 2'd0,
    ACT_ALLOC_RUN = 2'd1,
    ACT_FREE_ONE  = 2'd2,
    ACT_FREE_RUN  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  localparam logic CFG_BASE_FRAME = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_SCAN,
    S_MARK,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[design/bitmap_page_allocator.sv]
// Top level: bitmap page-frame allocator with a word-wide bitmap memory.
// One item at a time; the next is taken the cycle after DONE, and the result
// register lets it start while the previous result waits on out_stall.
// After reset a clearing pass zeroes the bitmap, one word a cycle.
`default_nettype none
module bitmap_page_allocator #(
  parameter int PAGES     = 4096,
  parameter int WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [51:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_action,
  input  wire logic [51:0]          in_page_frame,
  input  wire logic [12:0]          in_run_length,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [51:0]               out_result_frame,
  output logic [1:0]                out_status,
  output logic [12:0]               out_free_pages,
  output logic [12:0]               out_used_pages
);
  localparam int NWORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int PW     = $clog2(PAGES + 1);
  localparam int IW     = PW + 1;

  // configuration registers
  logic [51:0] base_frame_r;
  logic [12:0] pool_pages_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_frame_r <= '0;
      pool_pages_r <= 13'd4096;
    end else if (cfg_we) begin
      if (cfg_index == bpa_pkg::CFG_BASE_FRAME) base_frame_r <= cfg_data;
      else pool_pages_r <= cfg_data[12:0];
    end
  end

  // pool size clamped to PAGES
  logic [PW-1:0] n_pool;
  always_comb begin
    if ({{(IW > 13 ? IW-13 : 0){1'b0}}, pool_pages_r} > IW'(PAGES)) n_pool = PW'(PAGES);
    else n_pool = PW'(pool_pages_r);
  end

  // bitmap memory
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd, mem_rd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  bpa_pkg::state_t state_r, state_nxt;
  logic [1:0]      act_r;
  logic [51:0]     frame_r;
  logic [12:0]     len_r;
  logic [PW-1:0]   p_r, p_nxt;       // current page
  logic [PW-1:0]   i_r, i_nxt;       // pages visited (alloc one) / pages left (mark, free)
  logic [PW-1:0]   run_r, run_nxt;
  logic [PW-1:0]   s_r, s_nxt;       // run start
  logic [PW-1:0]   cursor_r, cursor_nxt;
  logic [PW-1:0]   used_r, used_nxt;
  logic [AW-1:0]   clr_r;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;
  logic            wvalid_r, wvalid_nxt;
  logic [51:0]     res_r, res_nxt;
  logic [1:0]      st_r, st_nxt;
  logic            ov_r;
  logic            scan_pending;     // memory data lands in this SCAN cycle

  logic [PW-1:0] free_cnt;
  assign free_cnt = (n_pool > used_r) ? n_pool - used_r : '0;

  logic [AW-1:0] p_word;
  logic [BW-1:0] p_bit;
  assign p_word = AW'(p_r / WORD_BITS);
  assign p_bit  = BW'(p_r % WORD_BITS);

  // word under scan: fresh read data on the first cycle after S_RD
  logic [WORD_BITS-1:0] scan_word;
  assign scan_word = scan_pending ? mem_rd : word_r;

  logic cur_bit;
  always_comb cur_bit = scan_word[BW'(WORD_BITS-1) - p_bit];

  // frame offset check for frees
  logic [52:0] off;
  logic [13:0] cnt_eff;
  logic        free_bad;
  always_comb begin
    off = {1'b0, frame_r} - {1'b0, base_frame_r};
    cnt_eff = (act_r == bpa_pkg::ACT_FREE_ONE) ? 14'd1 : {1'b0, len_r};
    free_bad = off[52] || (off[51:0] >= 52'(n_pool)) ||
               (53'(cnt_eff) > (53'(n_pool) - off));
  end

  // result register can take a new result
  logic out_free;
  assign out_free = !(ov_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR:   if (clr_r == AW'(NWORDS-1)) state_nxt = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:    if (in_valid) state_nxt = bpa_pkg::S_CHECK;
      bpa_pkg::S_CHECK: begin
        if (act_r == bpa_pkg::ACT_ALLOC_ONE || act_r == bpa_pkg::ACT_ALLOC_RUN) begin
          if (n_pool == '0) state_nxt = bpa_pkg::S_DONE;
          else if (act_r == bpa_pkg::ACT_ALLOC_RUN &&
                   (len_r == '0 || 14'(len_r) > 14'(free_cnt))) state_nxt = bpa_pkg::S_DONE;
          else state_nxt = bpa_pkg::S_RD;
        end else if (cnt_eff == '0 || free_bad) state_nxt = bpa_pkg::S_DONE;
        else state_nxt = bpa_pkg::S_FREE_RD;
      end
      bpa_pkg::S_RD:      state_nxt = bpa_pkg::S_SCAN;
      bpa_pkg::S_SCAN: begin
        if (act_r == bpa_pkg::ACT_ALLOC_ONE) begin
          if (!cur_bit) state_nxt = bpa_pkg::S_DONE;
          else if (i_r + 1'b1 == n_pool) state_nxt = bpa_pkg::S_DONE;
          else if (p_bit == BW'(WORD_BITS-1) || p_r + 1'b1 == n_pool) state_nxt = bpa_pkg::S_RD;
        end else begin
          if (!cur_bit && 14'(run_r) + 14'd1 == 14'(len_r)) state_nxt = bpa_pkg::S_MARK;
          else if (p_r + 1'b1 == n_pool) state_nxt = bpa_pkg::S_DONE;
          else if (p_bit == BW'(WORD_BITS-1)) state_nxt = bpa_pkg::S_RD;
        end
      end
      bpa_pkg::S_MARK:    state_nxt = bpa_pkg::S_FREE_WR;
      bpa_pkg::S_FREE_RD: state_nxt = bpa_pkg::S_FREE_WR;
      bpa_pkg::S_FREE_WR: begin
        if (i_r == '0) state_nxt = bpa_pkg::S_DONE;
        else state_nxt = bpa_pkg::S_FREE_RD;
      end
      bpa_pkg::S_DONE:    if (out_free) state_nxt = bpa_pkg::S_IDLE;
      default:            state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    p_nxt = p_r; i_nxt = i_r; run_nxt = run_r; s_nxt = s_r;
    cursor_nxt = cursor_r; used_nxt = used_r; word_nxt = word_r;
    wa_nxt = wa_r; wvalid_nxt = wvalid_r; res_nxt = res_r; st_nxt = st_r;
    mem_we = 1'b0; mem_wa = clr_r; mem_wd = '0; mem_ra = p_word;
    unique case (state_r)
      bpa_pkg::S_CLEAR: mem_we = 1'b1;
      bpa_pkg::S_IDLE: begin
        res_nxt = '0; st_nxt = bpa_pkg::ST_OK;
      end
      bpa_pkg::S_CHECK: begin
        i_nxt = '0; run_nxt = '0; wvalid_nxt = 1'b0;
        if (act_r == bpa_pkg::ACT_ALLOC_ONE) begin
          p_nxt = (cursor_r < n_pool) ? cursor_r : '0;
          st_nxt = bpa_pkg::ST_OOM;
        end else if (act_r == bpa_pkg::ACT_ALLOC_RUN) begin
          p_nxt = '0;
          st_nxt = (len_r == '0) ? bpa_pkg::ST_BAD : bpa_pkg::ST_OOM;
        end else if (cnt_eff == '0) begin
          res_nxt = frame_r;
        end else if (free_bad) begin
          st_nxt = bpa_pkg::ST_BAD;
        end else begin
          p_nxt = PW'(off);
          i_nxt = PW'(cnt_eff - 14'd1);
          res_nxt = frame_r;
        end
      end
      bpa_pkg::S_RD: mem_ra = p_word;
      bpa_pkg::S_SCAN: begin
        if (act_r == bpa_pkg::ACT_ALLOC_ONE) begin
          if (!cur_bit) begin
            word_nxt = scan_word;
            word_nxt[BW'(WORD_BITS-1) - p_bit] = 1'b1;
            mem_we = 1'b1; mem_wa = p_word; mem_wd = word_nxt;
            used_nxt = used_r + 1'b1;
            cursor_nxt = p_r;
            res_nxt = base_frame_r + 52'(p_r);
            st_nxt = bpa_pkg::ST_OK;
          end else begin
            i_nxt = i_r + 1'b1;
            p_nxt = (p_r + 1'b1 == n_pool) ? '0 : p_r + 1'b1;
          end
        end else begin
          if (!cur_bit && 14'(run_r) + 14'd1 == 14'(len_r)) begin
            s_nxt = PW'(14'(p_r) + 14'd1 - 14'(len_r));
            p_nxt = PW'(14'(p_r) + 14'd1 - 14'(len_r));
            i_nxt = PW'(len_r - 13'd1);
          end else begin
            run_nxt = cur_bit ? '0 : run_r + 1'b1;
            p_nxt = p_r + 1'b1;
          end
        end
      end
      bpa_pkg::S_MARK: begin
        res_nxt = base_frame_r + 52'(s_r);
        st_nxt = bpa_pkg::ST_OK;
        mem_ra = p_word;
      end
      bpa_pkg::S_FREE_RD: mem_ra = p_word;
      bpa_pkg::S_FREE_WR: begin
        // forward the word just written when the walk stays in it
        word_nxt = (wvalid_r && wa_r == p_word) ? word_r : mem_rd;
        if (act_r == bpa_pkg::ACT_ALLOC_RUN) begin
          if (!word_nxt[BW'(WORD_BITS-1) - p_bit]) used_nxt = used_r + 1'b1;
          word_nxt[BW'(WORD_BITS-1) - p_bit] = 1'b1;
        end else begin
          if (word_nxt[BW'(WORD_BITS-1) - p_bit]) used_nxt = used_r - 1'b1;
          word_nxt[BW'(WORD_BITS-1) - p_bit] = 1'b0;
        end
        mem_we = 1'b1; mem_wa = p_word; mem_wd = word_nxt;
        wa_nxt = p_word; wvalid_nxt = 1'b1;
        p_nxt = p_r + 1'b1; i_nxt = i_r - 1'b1;
      end
      default: ;
    endcase
  end

  // scan word capture: the read returns in the cycle after S_RD
  logic load_word;
  assign load_word = (state_r == bpa_pkg::S_RD);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_CLEAR;
      clr_r <= '0; cursor_r <= '0; used_r <= '0; ov_r <= 1'b0; wvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bpa_pkg::S_CLEAR) clr_r <= clr_r + 1'b1;
      cursor_r <= cursor_nxt; used_r <= used_nxt; wvalid_r <= wvalid_nxt;
      if (state_r == bpa_pkg::S_DONE && out_free) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; i_r <= i_nxt; run_r <= run_nxt; s_r <= s_nxt;
    wa_r <= wa_nxt; res_r <= res_nxt; st_r <= st_nxt;
    scan_pending <= load_word;
    if (state_r == bpa_pkg::S_IDLE) begin
      act_r <= in_action; frame_r <= in_page_frame; len_r <= in_run_length;
    end
    if (scan_pending) word_r <= mem_rd;
    else word_r <= word_nxt;
    if (state_r == bpa_pkg::S_DONE && out_free) begin
      out_result_frame <= res_r;
      out_status <= st_r;
      out_used_pages <= 13'(used_r);
      out_free_pages <= 13'(free_cnt);
    end
  end

  assign in_stall  = (state_r != bpa_pkg::S_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire

[design/bpa_checker.sv]
// Checker: port-level properties of the page allocator, bound to the top level.
`default_nettype none
module bpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [12:0] out_free_pages,
  input wire logic [12:0] out_used_pages
);
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken straight after an item");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_free_pages != 13'd0 |->
      {1'b0, out_free_pages} + {1'b0, out_used_pages} <= 14'd4096)
    else $error("counts exceed pool");
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_free_pages(out_free_pages), .out_used_pages(out_used_pages)
);
`default_nettype wire
